FILE: design/lpw_pkg.sv
package lpw_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // command from the handshake side into the walker
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_cmd;

    // walker status for the point currently held
    typedef struct packed {
        logic active;
        logic last;
    } t_walk_stat;

endpackage

FILE: design/lpw_in_if.sv
interface lpw_in_if
    import lpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    t_op                   op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  blend_mode;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, pixel_color, blend_mode,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, pixel_color, blend_mode,
        output ready
    );
endinterface

FILE: design/lpw_out_if.sv
interface lpw_out_if
    import lpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COLOR_BITS-1:0] point_color;
    logic                  point_blend;
    logic                  valid_res;
    logic                  last;

    modport source (
        output valid, point_x, point_y, point_color, point_blend, valid_res, last,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_color, point_blend, valid_res, last,
        output ready
    );
endinterface

FILE: design/lpw_walk.sv
module lpw_walk
    import lpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_walk_cmd             i_cmd,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_color,
    input  logic                  i_blend,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic [COLOR_BITS-1:0] o_color,
    output logic                  o_blend,
    output t_walk_stat            o_stat
);

    localparam int EW = COORD_BITS + 2;  // stored error term
    localparam int SW = COORD_BITS + 3;  // trial sums

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    logic [COORD_BITS-1:0] r_span_x, r_span_y;
    logic                  r_y_down;
    logic signed [EW-1:0]  r_err;
    logic                  r_active;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_blend;

    logic                  swap;
    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic                  fin;
    logic signed [SW-1:0]  err_ext, ex, ey;
    logic [SW-1:0]         abs_ex, abs_ey;
    logic                  move_x;

    // order endpoints as a pair by x
    always_comb begin
        swap = (i_end_x < i_start_x);
        ax   = swap ? i_end_x   : i_start_x;
        ay   = swap ? i_end_y   : i_start_y;
        bx   = swap ? i_start_x : i_end_x;
        by   = swap ? i_start_y : i_end_y;
    end

    always_comb begin
        fin     = (r_cur_x == r_stop_x) && (r_cur_y == r_stop_y);
        err_ext = {r_err[EW-1], r_err};
        ex      = err_ext + $signed({3'b000, r_span_y});
        ey      = err_ext - $signed({3'b000, r_span_x});
        abs_ex  = ex[SW-1] ? SW'(-ex) : SW'(ex);
        abs_ey  = ey[SW-1] ? SW'(-ey) : SW'(ey);
        // tie goes to y
        move_x  = (abs_ex < abs_ey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_stop_x <= '0;
            r_stop_y <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
            r_y_down <= 1'b0;
            r_err    <= '0;
            r_active <= 1'b0;
            r_color  <= '0;
            r_blend  <= 1'b0;
        end else if (i_cmd.load) begin
            r_cur_x  <= ax;
            r_cur_y  <= ay;
            r_stop_x <= bx;
            r_stop_y <= by;
            r_span_x <= bx - ax;
            r_y_down <= (by < ay);
            r_span_y <= (by < ay) ? (ay - by) : (by - ay);
            r_err    <= '0;
            r_active <= 1'b1;
            r_color  <= i_color;
            r_blend  <= i_blend;
        end else if (i_cmd.step && r_active) begin
            if (fin) begin
                r_active <= 1'b0;
            end else if (move_x) begin
                r_err   <= ex[EW-1:0];
                r_cur_x <= r_cur_x + 1'b1;
            end else begin
                r_err   <= ey[EW-1:0];
                r_cur_y <= r_y_down ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
            end
        end
    end

    assign o_x         = r_cur_x;
    assign o_y         = r_cur_y;
    assign o_color     = r_color;
    assign o_blend     = r_blend;
    assign o_stat.active = r_active;
    assign o_stat.last   = fin;

`ifndef NO_ASSERTIONS
    // a finished line drops out of the walk
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load && r_active && fin) |=> !r_active)
        else $error("walk stayed active after last point");

    // a move changes exactly one coordinate
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load && r_active && !fin)
        |=> ((r_cur_x != $past(r_cur_x)) != (r_cur_y != $past(r_cur_y))))
        else $error("step did not move along exactly one axis");
`endif

endmodule

FILE: design/line_point_walker_core.sv
// Four-connected line rasterizer core.
// Output: a step transfer shows its point on the output in the next cycle.
// Throughput: one item per cycle while o_out.ready holds; the output register
// is refilled in the cycle it is taken, and a load gives no output item.
// Reset: synchronous active-low; clears the walk (no line active) and o_out.valid.
module line_point_walker_core
    import lpw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpw_in_if.sink         i_in,
    lpw_out_if.source      o_out
);

    t_walk_cmd             walk_cmd;
    t_walk_stat            walk_stat;
    logic [COORD_BITS-1:0] walk_x, walk_y;
    logic [COLOR_BITS-1:0] walk_color;
    logic                  walk_blend;
    logic                  in_xfer;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_point_x, r_point_y;
    logic [COLOR_BITS-1:0] r_point_color;
    logic                  r_point_blend, r_valid_res, r_last;

    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign in_xfer       = i_in.valid && i_in.ready;
    assign walk_cmd.load = in_xfer && (i_in.op == OP_LOAD);
    assign walk_cmd.step = in_xfer && (i_in.op == OP_STEP);

    lpw_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (walk_cmd),
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .i_end_x   (i_in.end_x),
        .i_end_y   (i_in.end_y),
        .i_color   (i_in.pixel_color),
        .i_blend   (i_in.blend_mode),
        .o_x       (walk_x),
        .o_y       (walk_y),
        .o_color   (walk_color),
        .o_blend   (walk_blend),
        .o_stat    (walk_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (walk_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // capture the current point; zeros when no line is active
    always_ff @(posedge i_clk) begin
        if (walk_cmd.step) begin
            r_point_x     <= walk_stat.active ? walk_x : '0;
            r_point_y     <= walk_stat.active ? walk_y : '0;
            r_point_color <= walk_stat.active ? walk_color : '0;
            r_point_blend <= walk_stat.active && walk_blend;
            r_valid_res   <= walk_stat.active;
            r_last        <= walk_stat.active && walk_stat.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_x     = r_point_x;
    assign o_out.point_y     = r_point_y;
    assign o_out.point_color = r_point_color;
    assign o_out.point_blend = r_point_blend;
    assign o_out.valid_res   = r_valid_res;
    assign o_out.last        = r_last;

`ifndef NO_ASSERTIONS
    // a step with no line gives an empty point
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_cmd.step && !walk_stat.active) |=> (r_out_valid && !r_valid_res && !r_last))
        else $error("step without a line did not give an empty result");

    // a load starts a line and never produces an output item by itself
    a_load_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_cmd.load |=> walk_stat.active)
        else $error("load did not start a line");

    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_cmd.load && (!r_out_valid || o_out.ready)) |=> !r_out_valid)
        else $error("load produced an output item");

    // an emitted last point always carries a valid point
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_valid_res)
        else $error("last flagged on an empty result");
`endif

endmodule
